// ===== rtl/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator.
// Sizes, field widths, action codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package bpfa_pkg;

	// map geometry
	localparam int PAGES     = 4096;
	localparam int BIT_W     = 3;                 // page bit within a map byte
	localparam int MAP_DEPTH = PAGES / 8;         // map bytes
	localparam int ROW_W     = $clog2(MAP_DEPTH); // map byte address

	// field widths
	localparam int ACT_W  = 2;
	localparam int PAGE_W = 13;
	localparam int CNT_W  = 13;
	localparam int IDX_W  = 12;
	localparam int MAPB_W = 10;

	localparam logic [MAPB_W-1:0] MAP_BYTES_RST = MAPB_W'(512);
	localparam logic [7:0]        FULL_BYTE     = 8'hFF;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_MARK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;   // write one byte of the reset sweep
		logic start;    // capture the input beat
		logic setup;    // set up row range and hint
		logic rd;       // read the current row
		logic eval;     // modify/search the row just read
		logic out_load; // move result into the output register
	} bpfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;   // last byte of the reset sweep
		logic is_alloc;
		logic is_range;   // free or mark-used
		logic run_empty;  // range op touches no page below the limit
		logic scan_empty; // hint at or above the limit
		logic hit;        // row read holds a free page in the scan window
		logic row_last;   // current row is the last one to visit
	} bpfa_sts_t;

endpackage

// ===== rtl/bpfa_dpath.sv =====
// Datapath of the bitmap page frame allocator: usage map memory, hint,
// map size register, row walker, bit masks and result/output registers.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_dpath import bpfa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpfa_cmd_t             cmd,
	output bpfa_sts_t             sts,
	input  logic                  cfg_we,
	input  logic [MAPB_W-1:0]     cfg_data,
	input  logic [ACT_W-1:0]      action,
	input  logic [PAGE_W-1:0]     first_page,
	input  logic [CNT_W-1:0]      page_count,
	output logic [IDX_W-1:0]      frame_index,
	output logic                  found
);

	logic [7:0]        mem [MAP_DEPTH];
	logic [7:0]        rd_data_q;
	logic [ROW_W-1:0]  clr_cnt_q;
	logic [MAPB_W-1:0] map_bytes_q;
	logic [PAGE_W-1:0] hint_q;

	action_t           act_q;
	logic [PAGE_W-1:0] first_q;
	logic [PAGE_W-1:0] endc_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  start_row_q;
	logic [ROW_W-1:0]  last_row_q;
	logic [BIT_W-1:0]  lo_q;
	logic [BIT_W-1:0]  hi_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  frame_index_q;
	logic              found_q;

	logic [MAPB_W-1:0] lim_rows;
	logic [PAGE_W-1:0] lim_pages;
	logic [PAGE_W:0]   run_end;
	logic [PAGE_W-1:0] endc_m1;
	logic [MAPB_W-1:0] lim_rows_m1;
	logic [7:0]        in_mask;
	logic [7:0]        avail;
	logic [BIT_W-1:0]  pick;
	logic              hit;
	logic              run_empty;
	logic              scan_empty;
	logic [7:0]        wr_data;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_addr;

	// page limit, whole bytes, saturated at the map depth
	assign lim_rows    = (map_bytes_q > MAPB_W'(MAP_DEPTH)) ? MAPB_W'(MAP_DEPTH) : map_bytes_q;
	assign lim_pages   = {lim_rows, BIT_W'(0)};
	assign lim_rows_m1 = lim_rows - MAPB_W'(1);

	// end of the run, clipped to the limit
	assign run_end = {1'b0, first_page} + {1'b0, page_count};
	assign endc_m1 = endc_q - PAGE_W'(1);

	assign run_empty  = first_q >= endc_q;
	assign scan_empty = hint_q >= lim_pages;

	// pages of the current row inside the window
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			in_mask[b] = ((row_q != start_row_q) || (BIT_W'(b) >= lo_q)) &&
				((row_q != last_row_q) || (BIT_W'(b) <= hi_q));
		end
	end

	// lowest free page in the window
	assign avail = ~rd_data_q & in_mask;
	assign hit   = |avail;
	always_comb begin
		pick = '0;
		for (int b = 7; b >= 0; b--) begin
			if (avail[b]) begin
				pick = BIT_W'(b);
			end
		end
	end

	// memory write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = rd_data_q;
		if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = FULL_BYTE;
		end else if (cmd.eval) begin
			case (act_q)
				ACT_ALLOC: begin
					wr_en   = hit;
					wr_data = rd_data_q | (8'd1 << pick);
				end
				ACT_FREE: begin
					wr_en   = 1'b1;
					wr_data = rd_data_q & ~in_mask;
				end
				ACT_MARK: begin
					wr_en   = 1'b1;
					wr_data = rd_data_q | in_mask;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// usage map
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[row_q];
		end
	end

	// control registers: sweep counter, map size, hint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			map_bytes_q <= MAP_BYTES_RST;
			hint_q      <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + ROW_W'(1);
			end
			if (cfg_we) begin
				map_bytes_q <= cfg_data;
			end
			// free lowers the hint to the first page it clears
			if (cmd.setup && act_q == ACT_FREE && !run_empty && first_q < hint_q) begin
				hint_q <= first_q;
			end
			if (cmd.eval && act_q == ACT_ALLOC && hit) begin
				hint_q <= PAGE_W'({row_q, pick}) + PAGE_W'(1);
			end
		end
	end

	// item, walker and result registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q   <= action_t'(action);
			first_q <= first_page;
			endc_q  <= (run_end > {1'b0, lim_pages}) ? lim_pages : run_end[PAGE_W-1:0];
		end
		if (cmd.setup) begin
			res_index_q <= '0;
			res_found_q <= 1'b0;
			if (act_q == ACT_ALLOC) begin
				row_q       <= hint_q[ROW_W+BIT_W-1:BIT_W];
				start_row_q <= hint_q[ROW_W+BIT_W-1:BIT_W];
				lo_q        <= hint_q[BIT_W-1:0];
				last_row_q  <= lim_rows_m1[ROW_W-1:0];
				hi_q        <= '1;
			end else begin
				row_q       <= first_q[ROW_W+BIT_W-1:BIT_W];
				start_row_q <= first_q[ROW_W+BIT_W-1:BIT_W];
				lo_q        <= first_q[BIT_W-1:0];
				last_row_q  <= endc_m1[ROW_W+BIT_W-1:BIT_W];
				hi_q        <= endc_m1[BIT_W-1:0];
			end
		end
		if (cmd.eval) begin
			row_q <= row_q + ROW_W'(1);
			if (act_q == ACT_ALLOC && hit) begin
				res_index_q <= {row_q, pick};
				res_found_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			frame_index_q <= res_index_q;
			found_q       <= res_found_q;
		end
	end

	assign frame_index = frame_index_q;
	assign found       = found_q;

	assign sts.clr_last   = clr_cnt_q == ROW_W'(MAP_DEPTH - 1);
	assign sts.is_alloc   = act_q == ACT_ALLOC;
	assign sts.is_range   = (act_q == ACT_FREE) || (act_q == ACT_MARK);
	assign sts.run_empty  = run_empty;
	assign sts.scan_empty = scan_empty;
	assign sts.hit        = hit;
	assign sts.row_last   = row_q == last_row_q;

	// sweep write and row update never share the write port
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && cmd.eval))
		else $error("sweep write collides with row update");

	// a free never leaves the hint above its first page
	a_free_hint: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.setup && act_q == ACT_FREE && !run_empty) |=> hint_q <= $past(first_q))
		else $error("hint not lowered by free");

	// an allocation hit stays below the page limit
	a_hit_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && act_q == ACT_ALLOC && hit) |-> (MAPB_W'(row_q) < lim_rows))
		else $error("allocation beyond page limit");

endmodule

// ===== rtl/bpfa_ctrl.sv =====
// Controller of the bitmap page frame allocator: reset sweep, row walk
// sequencing and the output handshake.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_ctrl import bpfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  bpfa_sts_t sts,
	output bpfa_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_EVAL,
		ST_POST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// commands
	assign in_ready     = state_q == ST_IDLE;
	assign cmd.clr_wr   = state_q == ST_CLEAR;
	assign cmd.start    = in_valid && state_q == ST_IDLE;
	assign cmd.setup    = state_q == ST_SETUP;
	assign cmd.rd       = state_q == ST_READ;
	assign cmd.eval     = state_q == ST_EVAL;
	assign cmd.out_load = state_q == ST_POST && out_free;
	assign out_valid    = out_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (sts.is_alloc && !sts.scan_empty) begin
						state_q <= ST_READ;
					end else if (sts.is_range && !sts.run_empty) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if ((sts.is_alloc && sts.hit) || sts.row_last) begin
						state_q <= ST_POST;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a loaded result is presented next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result loaded but not presented");

	// row evaluation always follows a row read
	a_eval_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_READ)
		else $error("row evaluated without a read");

	// a result waiting on a full output register holds its state
	a_post_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST && out_valid_q && !out_ready) |=> state_q == ST_POST)
		else $error("result dropped while output stalled");

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator, first fit.
// Ties the controller and datapath together. Depends on bpfa_pkg,
// bpfa_ctrl and bpfa_dpath.
//
//  channel | signals                                  | dir | beat
//  --------+------------------------------------------+-----+-------------------------
//  in      | in_valid in_ready action first_page      | in  | one request
//          | page_count                               |     |
//  out     | out_valid out_ready frame_index found    | out | one result per request
//  cfg     | cfg_valid cfg_ready cfg_data             | in  | map_bytes write
//
// A request makes one read and one read-modify-write per map byte visited, on
// the single map memory port. Allocate walks
// bytes from the hint until a free page; free/mark-used walk the run's bytes.
// After reset a sweep sets every map byte to all used; in_ready is
// low meanwhile, configuration writes are taken at all times.
// A new request is taken while the previous result waits in the output
// register; a finished result waits in the datapath until that register frees.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator import bpfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [PAGE_W-1:0] first_page,
	input  logic [CNT_W-1:0]  page_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  frame_index,
	output logic              found,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MAPB_W-1:0] cfg_data
);

	bpfa_cmd_t cmd;
	bpfa_sts_t sts;

	// map size register always takes a write
	assign cfg_ready = 1'b1;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpfa_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid),
		.cfg_data    (cfg_data),
		.action      (action),
		.first_page  (first_page),
		.page_count  (page_count),
		.frame_index (frame_index),
		.found       (found)
	);

endmodule
